[design/brcu_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the bandwidth-ratio cwnd update core.
// No dependencies.
package brcu_pkg;

  localparam int unsigned BwW     = 40;
  localparam int unsigned AckW    = 16;
  localparam int unsigned CwndW   = 32;
  localparam int unsigned SegW    = 16;
  localparam int unsigned RemW    = BwW + 1;
  localparam int unsigned InDataW = 88;
  localparam int unsigned DivCntW = 5;

  localparam logic [SegW-1:0] SegReset = 16'd1448;

  typedef enum logic [1:0] {
    REGION_LIGHT  = 2'd0,
    REGION_NORMAL = 2'd1,
    REGION_DECAY  = 2'd2,
    REGION_NOACK  = 2'd3
  } region_e;

  typedef enum logic [1:0] {
    DIV_WIN   = 2'd0,
    DIV_ADD   = 2'd1,
    DIV_DECAY = 2'd2
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_EVAL     = 4'd1,
    ST_WIN_DIV  = 4'd2,
    ST_ADD_LOAD = 4'd3,
    ST_ADD_DIV  = 4'd4,
    ST_MUL_LO   = 4'd5,
    ST_MUL_HI   = 4'd6,
    ST_DEC_LOAD = 4'd7,
    ST_DEC_DIV  = 4'd8,
    ST_DONE     = 4'd9
  } state_e;

  typedef struct packed {
    logic     load_item;
    logic     calc_sum;
    logic     mul_lo;
    logic     mul_hi;
    logic     div_load;
    div_sel_e div_sel;
    logic     div_step;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    region_e region;
    logic    div_last;
    logic    out_busy;
  } dp_status_t;

endpackage

[design/bandwidth_ratio_cwnd_update_core.sv]
`timescale 1ns / 1ps
// Bandwidth-ratio congestion window update core, top level.
// Depends on brcu_pkg, brcu_ctrl, brcu_dp (and brcu_div below it).
//
// Usage:
//   Slave stream: one beat per ACK event, tdata = {cwnd_in, acked_count,
//   current_bw}. Master stream: one beat per event, tdata = cwnd_out,
//   tuser = load_region. cfg_* writes seg_size; write it only while idle.
//   One event is processed at a time; s_axis_tready is high only when idle.
//   Steps per event, using the serial divider passes:
//     growth (light/normal): window divide, then step divide
//     proportional decay:    two split multiplies, one divide
//     no ack:                no divide, cwnd_in is passed on
//   The next input beat can be taken in the cycle after the result is registered.
//   A stalled master keeps the result in the output register; the core
//   still takes and works on the next event and holds it until the
//   output register frees up.
//   Reset clears the kept bandwidth estimate to zero, seg_size to 1448
//   and empties the output register.
module bandwidth_ratio_cwnd_update_core import brcu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,  // current_bw[39:0], acked_count[55:40], cwnd_in[87:56]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [CwndW-1:0]   m_axis_tdata,  // cwnd_out[31:0]
  output logic [1:0]         m_axis_tuser,  // load_region[1:0]
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [SegW-1:0]    cfg_data_i     // seg_size[15:0]
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  brcu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  brcu_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_data_i    (s_axis_tdata),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_cwnd_o   (m_axis_tdata),
    .out_region_o (m_axis_tuser)
  );

endmodule

[design/brcu_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle while step_i is high, 32 quotient bits.
// Depends on brcu_pkg. Remainder preload must be below the divisor.
module brcu_div import brcu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             step_i,
  input  logic [RemW-1:0]  rem_init_i,
  input  logic [CwndW-1:0] dvd_init_i,
  input  logic [RemW-1:0]  dsr_i,
  output logic [CwndW-1:0] quo_o,
  output logic             last_o
);

  logic [RemW-1:0]    rem_q, rem_d;
  logic [CwndW-1:0]   dvd_q, dvd_d;
  logic [RemW-1:0]    dsr_q;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [RemW:0]      trial;
  logic [RemW:0]      diff;
  logic               ge;

  assign trial = {rem_q, dvd_q[CwndW-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    cnt_d = cnt_q;
    if (load_i) begin
      rem_d = rem_init_i;
      dvd_d = dvd_init_i;
      cnt_d = '0;
    end else if (step_i) begin
      rem_d = ge ? diff[RemW-1:0] : trial[RemW-1:0];
      dvd_d = {dvd_q[CwndW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    if (load_i) begin
      dsr_q <= dsr_i;
    end
  end

  assign quo_o  = dvd_q;
  assign last_o = (cnt_q == {DivCntW{1'b1}});

endmodule

[design/brcu_dp.sv]
`timescale 1ns / 1ps
// Datapath: item and state registers, region decode, split multiply,
// divider operand selection and result register. Depends on brcu_pkg, brcu_div.
module brcu_dp import brcu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [InDataW-1:0] in_data_i,
  input  logic               cfg_we_i,
  input  logic [SegW-1:0]    cfg_data_i,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [CwndW-1:0]   out_cwnd_o,
  output logic [1:0]         out_region_o
);

  logic [SegW-1:0]  seg_q;
  logic [BwW-1:0]   cur_q, prev_q;
  logic [CwndW-1:0] cwnd_q;
  logic             ack_zero_q;
  logic [RemW-1:0]  sum_q;
  logic [63:0]      p0_q;
  logic [RemW-1:0]  p1_q;
  logic             out_valid_q;
  logic [CwndW-1:0] out_cwnd_q, out_cwnd_d;
  region_e          out_region_q;

  logic [SegW-1:0]  seg_eff;
  logic [RemW:0]    prev3, cur2;
  region_e          region;
  logic [72:0]      prod;
  logic [RemW-1:0]  rem_init, dsr;
  logic [CwndW-1:0] dvd_init;
  logic [CwndW-1:0] quo, quo_eff;
  logic             div_last;
  logic [SegW:0]    add_num;
  logic [CwndW:0]   grow;

  assign seg_eff = (seg_q == '0) ? {{(SegW-1){1'b0}}, 1'b1} : seg_q;
  assign prev3   = {2'b00, prev_q} + {1'b0, prev_q, 1'b0};
  assign cur2    = {1'b0, cur_q, 1'b0};

  always_comb begin
    priority if (ack_zero_q) begin
      region = REGION_NOACK;
    end else if (prev_q != '0 && cur_q < prev_q) begin
      region = REGION_DECAY;
    end else if (prev_q != '0 && cur2 >= prev3) begin
      region = REGION_LIGHT;
    end else begin
      region = REGION_NORMAL;
    end
  end

  assign prod    = {9'd0, p0_q} + {p1_q, 32'd0};
  assign quo_eff = (quo == '0) ? {{(CwndW-1){1'b0}}, 1'b1} : quo;
  assign add_num = (region == REGION_LIGHT) ? {seg_eff, 1'b0} : {1'b0, seg_eff};

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_WIN: begin
        rem_init = '0;
        dvd_init = cwnd_q;
        dsr      = {{(RemW-SegW){1'b0}}, seg_eff};
      end
      DIV_ADD: begin
        rem_init = '0;
        dvd_init = {{(CwndW-SegW-1){1'b0}}, add_num};
        dsr      = {{(RemW-CwndW){1'b0}}, quo_eff};
      end
      DIV_DECAY: begin
        rem_init = prod[72:32];
        dvd_init = prod[31:0];
        dsr      = {prev_q, 1'b0};
      end
      default: begin
        rem_init = '0;
        dvd_init = cwnd_q;
        dsr      = {{(RemW-SegW){1'b0}}, seg_eff};
      end
    endcase
  end

  brcu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (cmd_i.div_load),
    .step_i     (cmd_i.div_step),
    .rem_init_i (rem_init),
    .dvd_init_i (dvd_init),
    .dsr_i      (dsr),
    .quo_o      (quo),
    .last_o     (div_last)
  );

  assign grow = {1'b0, cwnd_q} + {1'b0, quo_eff};

  always_comb begin
    unique case (region)
      REGION_LIGHT, REGION_NORMAL: out_cwnd_d = grow[CwndW] ? '1 : grow[CwndW-1:0];
      REGION_DECAY: begin
        out_cwnd_d = (quo < {{(CwndW-SegW){1'b0}}, seg_eff}) ?
                     {{(CwndW-SegW){1'b0}}, seg_eff} : quo;
      end
      REGION_NOACK: out_cwnd_d = cwnd_q;
      default:      out_cwnd_d = cwnd_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= SegReset;
      prev_q      <= '0;
      ack_zero_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seg_q <= cfg_data_i;
      end
      if (cmd_i.load_item) begin
        ack_zero_q <= (in_data_i[55:40] == '0);
      end
      if (cmd_i.finish && region != REGION_NOACK) begin
        prev_q <= cur_q;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cur_q  <= in_data_i[39:0];
      cwnd_q <= in_data_i[87:56];
    end
    if (cmd_i.calc_sum) begin
      sum_q <= {1'b0, cur_q} + {1'b0, prev_q};
    end
    if (cmd_i.mul_lo) begin
      p0_q <= cwnd_q * sum_q[31:0];
    end
    if (cmd_i.mul_hi) begin
      p1_q <= cwnd_q * sum_q[RemW-1:32];
    end
    if (cmd_i.finish) begin
      out_cwnd_q   <= out_cwnd_d;
      out_region_q <= region;
    end
  end

  assign status_o.region   = region;
  assign status_o.div_last = div_last;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_cwnd_o   = out_cwnd_q;
  assign out_region_o = out_region_q;

endmodule

[design/brcu_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine sequencing decode, multiply and the divide passes (two for growth, one for decay).
// Depends on brcu_pkg.
module brcu_ctrl import brcu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        unique case (status_i.region)
          REGION_NOACK: state_d = ST_DONE;
          REGION_DECAY: state_d = ST_MUL_LO;
          default:      state_d = ST_WIN_DIV;
        endcase
      end
      ST_WIN_DIV: begin
        if (status_i.div_last) state_d = ST_ADD_LOAD;
      end
      ST_ADD_LOAD: state_d = ST_ADD_DIV;
      ST_ADD_DIV: begin
        if (status_i.div_last) state_d = ST_DONE;
      end
      ST_MUL_LO:   state_d = ST_MUL_HI;
      ST_MUL_HI:   state_d = ST_DEC_LOAD;
      ST_DEC_LOAD: state_d = ST_DEC_DIV;
      ST_DEC_DIV: begin
        if (status_i.div_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = DIV_WIN;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_EVAL: begin
        cmd_o.calc_sum = 1'b1;
        cmd_o.div_load = (status_i.region == REGION_LIGHT) ||
                         (status_i.region == REGION_NORMAL);
      end
      ST_ADD_LOAD: begin
        cmd_o.div_load = 1'b1;
        cmd_o.div_sel  = DIV_ADD;
      end
      ST_MUL_LO:   cmd_o.mul_lo = 1'b1;
      ST_MUL_HI:   cmd_o.mul_hi = 1'b1;
      ST_DEC_LOAD: begin
        cmd_o.div_load = 1'b1;
        cmd_o.div_sel  = DIV_DECAY;
      end
      ST_WIN_DIV, ST_ADD_DIV, ST_DEC_DIV: cmd_o.div_step = 1'b1;
      ST_DONE:     cmd_o.finish = !status_i.out_busy;
      default:     cmd_o.finish = 1'b0;
    endcase
  end

endmodule
